/* rtl/core/mle_pkg.sv */
`default_nettype none
package mle_pkg;

   localparam int NUM_BANDS_DEF    = 16;
   localparam int LONG_LINES_DEF   = 576;
   localparam int SHORT_LINES_DEF  = 192;
   localparam int GAIN_FRAC_DEF    = 16;

   localparam int DB_W             = 5;
   localparam int CENTER_W         = 15;
   localparam int GAIN_W           = 20;
   localparam int RATE_W           = 16;
   localparam int SAMPLE_W         = 32;
   localparam int LINE_W           = 10;
   localparam int STEP_W           = 8;
   localparam int FREQ_W           = 17;
   localparam int SPACE_W          = CENTER_W + 1;
   localparam int DIVN_W           = GAIN_W + 1 + STEP_W + 1;

   localparam logic [RATE_W-1:0] RATE_RESET = 16'd44100;
   localparam int DB_LIMIT         = 12;
   localparam int MIXED_LONG_LINES = 36;

   // rate/1152 = (rate>>7)/9, rate/384 = (rate>>7)/3, line/3 by reciprocal
   localparam int RATE_PRE_SH      = 7;
   localparam int RECIP9           = 57;
   localparam int RECIP3_STEP      = 171;
   localparam int RECIP_STEP_SH    = 9;
   localparam int RECIP3_LINE      = 683;
   localparam int RECIP_LINE_SH    = 11;

   localparam logic [GAIN_W-1:0] GAIN_TABLE [2*DB_LIMIT+1] = '{
      20'h0404D, 20'h04826, 20'h050F4, 20'h05AD5, 20'h065EA, 20'h07259,
      20'h0804D, 20'h08FF5, 20'h0A186, 20'h0B53B, 20'h0CB59, 20'h0E429,
      20'h10000, 20'h11F3C, 20'h14248, 20'h1699C, 20'h195BB, 20'h1C73D,
      20'h1FEC9, 20'h23D1C, 20'h2830A, 20'h2D181, 20'h3298B, 20'h38C52,
      20'h3FB27
   };

   typedef struct packed {
      logic signed [DB_W-1:0] db;
      logic [CENTER_W-1:0]    center;
   } band_ent_type;

   typedef struct packed {
      logic              we;
      logic              short_sel;
      logic [LINE_W-1:0] addr;
      logic [GAIN_W-1:0] data;
   } gain_wr_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bld_stat_type;

   function automatic logic [GAIN_W-1:0] gain_of_db(input logic signed [DB_W-1:0] d);
      logic signed [DB_W:0] sat;
      logic [DB_W-1:0]      idx;
      if (d < -DB_LIMIT)
         sat = (DB_W+1)'(-DB_LIMIT);
      else if (d > DB_LIMIT)
         sat = (DB_W+1)'(DB_LIMIT);
      else
         sat = (DB_W+1)'(d);
      idx = DB_W'(sat + (DB_W+1)'(DB_LIMIT));
      return GAIN_TABLE[idx];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/mle_band_store.sv */
`default_nettype none
module mle_band_store #(
   parameter int NUM_BANDS = mle_pkg::NUM_BANDS_DEF,
   localparam int BAW = $clog2(NUM_BANDS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [BAW-1:0]        wr_addr,
   input  wire mle_pkg::band_ent_type wr_data,
   input  wire logic [BAW-1:0]        rd_addr,
   output mle_pkg::band_ent_type      rd_data
);
   import mle_pkg::*;

   band_ent_type mem [NUM_BANDS];
   logic [NUM_BANDS-1:0] valid_ff;
   band_ent_type q_ff;
   logic qv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff  <= mem[rd_addr];
      qv_ff <= valid_ff[rd_addr];
   end

   assign rd_data = qv_ff ? q_ff : '0;

endmodule
`default_nettype wire

/* rtl/core/mle_slope_div.sv */
`default_nettype none
module mle_slope_div #(
   parameter int NUM_W = mle_pkg::DIVN_W,
   parameter int DEN_W = mle_pkg::SPACE_W
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic signed [DEN_W-1:0] den,
   output logic                         done,
   output logic signed [NUM_W-1:0]      quo
);
   import mle_pkg::*;

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] dmag_ff;
   logic             neg_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             ge;
   logic [DEN_W:0]   diff;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, dmag_ff};
   assign diff  = trial - {1'b0, dmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NUM_W);
            rem_ff  <= '0;
            quo_ff  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dmag_ff <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            neg_ff  <= num[NUM_W-1] ^ den[DEN_W-1];
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? $signed(-quo_ff) : $signed(quo_ff);

endmodule
`default_nettype wire

/* rtl/core/mle_gain_builder.sv */
`default_nettype none
module mle_gain_builder #(
   parameter int NUM_BANDS   = mle_pkg::NUM_BANDS_DEF,
   parameter int LONG_LINES  = mle_pkg::LONG_LINES_DEF,
   parameter int SHORT_LINES = mle_pkg::SHORT_LINES_DEF,
   localparam int BAW = $clog2(NUM_BANDS)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [mle_pkg::STEP_W-1:0]  step_long,
   input  wire logic [mle_pkg::STEP_W-1:0]  step_short,
   output logic [BAW-1:0]                   band_raddr,
   input  wire mle_pkg::band_ent_type       band_rdata,
   output mle_pkg::gain_wr_type             gain_wr,
   output mle_pkg::bld_stat_type            stat
);
   import mle_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE, B_RD0, B_RD1, B_LD1, B_SLOPE, B_DIV, B_RUN, B_LDN
   } bstate_type;

   bstate_type        state_ff;
   logic              pass_ff;
   logic [LINE_W-1:0] line_ff;
   logic [BAW-1:0]    band_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [GAIN_W-1:0] slope_ff;
   band_ent_type      cur_ff;
   band_ent_type      nxt_ff;
   logic              done_ff;

   logic [STEP_W-1:0]        step;
   logic [FREQ_W-1:0]        freq_in;
   logic                     has_next;
   logic                     adv;
   logic                     last;
   logic [BAW:0]             band_p2;
   logic signed [SPACE_W-1:0] spacing;
   logic signed [GAIN_W:0]   gdiff;
   logic signed [DIVN_W-1:0] dividend;
   logic                     div_start;
   logic                     div_done;
   logic signed [DIVN_W-1:0] div_quo;

   assign step     = pass_ff ? step_short : step_long;
   assign freq_in  = freq_ff + FREQ_W'(step);
   assign has_next = (int'(band_ff) + 1) < NUM_BANDS;
   assign adv      = has_next && (freq_in >= FREQ_W'(nxt_ff.center));
   assign last     = pass_ff ? (line_ff == LINE_W'(SHORT_LINES - 1))
                             : (line_ff == LINE_W'(LONG_LINES - 1));
   assign band_p2  = (BAW+1)'(band_ff) + (BAW+1)'(2);
   assign spacing  = $signed({1'b0, nxt_ff.center}) - $signed({1'b0, cur_ff.center});
   assign gdiff    = $signed({1'b0, gain_of_db(nxt_ff.db)})
                   - $signed({1'b0, gain_of_db(cur_ff.db)});
   assign dividend = DIVN_W'(gdiff * $signed({1'b0, step}));
   assign div_start = (state_ff == B_SLOPE) && has_next && (spacing != '0);

   always_comb begin
      unique case (state_ff)
         B_RD1:   band_raddr = BAW'(1);
         B_RUN:   band_raddr = band_p2[BAW-1:0];
         default: band_raddr = '0;
      endcase
   end

   mle_slope_div #(
      .NUM_W(DIVN_W),
      .DEN_W(SPACE_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(dividend),
      .den(spacing),
      .done(div_done),
      .quo(div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         pass_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (start) begin
                  pass_ff  <= 1'b0;
                  state_ff <= B_RD0;
               end
            end
            B_RD0: state_ff <= B_RD1;
            B_RD1: begin
               cur_ff   <= band_rdata;
               freq_ff  <= FREQ_W'(band_rdata.center);
               gain_ff  <= gain_of_db(band_rdata.db);
               band_ff  <= '0;
               line_ff  <= '0;
               state_ff <= B_LD1;
            end
            B_LD1: begin
               nxt_ff   <= band_rdata;
               state_ff <= B_SLOPE;
            end
            B_SLOPE: begin
               if (div_start) begin
                  state_ff <= B_DIV;
               end else begin
                  slope_ff <= '0;
                  state_ff <= B_RUN;
               end
            end
            B_DIV: begin
               if (div_done) begin
                  slope_ff <= div_quo[GAIN_W-1:0];
                  state_ff <= B_RUN;
               end
            end
            B_RUN: begin
               if (last) begin
                  if (!pass_ff) begin
                     pass_ff  <= 1'b1;
                     state_ff <= B_RD0;
                  end else begin
                     done_ff  <= 1'b1;
                     state_ff <= B_IDLE;
                  end
               end else begin
                  line_ff <= line_ff + LINE_W'(1);
                  freq_ff <= freq_in;
                  if (adv) begin
                     band_ff  <= band_ff + BAW'(1);
                     cur_ff   <= nxt_ff;
                     gain_ff  <= gain_of_db(nxt_ff.db);
                     state_ff <= B_LDN;
                  end else begin
                     gain_ff <= gain_ff + slope_ff;
                  end
               end
            end
            B_LDN: begin
               nxt_ff   <= band_rdata;
               state_ff <= B_SLOPE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign gain_wr.we        = (state_ff == B_RUN);
   assign gain_wr.short_sel = pass_ff;
   assign gain_wr.addr      = line_ff;
   assign gain_wr.data      = gain_ff;
   assign stat.busy         = (state_ff != B_IDLE);
   assign stat.done         = done_ff;

endmodule
`default_nettype wire

/* rtl/core/mle_gain_store.sv */
`default_nettype none
module mle_gain_store #(
   parameter int LONG_LINES  = mle_pkg::LONG_LINES_DEF,
   parameter int SHORT_LINES = mle_pkg::SHORT_LINES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mle_pkg::gain_wr_type        gain_wr,
   input  wire logic                        fill_done,
   input  wire logic                        rd_short,
   input  wire logic [mle_pkg::LINE_W-1:0]  rd_addr,
   output logic [mle_pkg::GAIN_W-1:0]       rd_gain
);
   import mle_pkg::*;

   localparam int LAW = $clog2(LONG_LINES);
   localparam int SAW = $clog2(SHORT_LINES);

   logic [GAIN_W-1:0] long_mem  [LONG_LINES];
   logic [GAIN_W-1:0] short_mem [SHORT_LINES];
   logic [GAIN_W-1:0] long_q_ff;
   logic [GAIN_W-1:0] short_q_ff;
   logic              sel_ff;
   logic              built_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         built_ff <= 1'b0;
      end else if (fill_done) begin
         built_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (gain_wr.we && !gain_wr.short_sel) begin
         long_mem[gain_wr.addr[LAW-1:0]] <= gain_wr.data;
      end
      long_q_ff <= long_mem[rd_addr[LAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (gain_wr.we && gain_wr.short_sel) begin
         short_mem[gain_wr.addr[SAW-1:0]] <= gain_wr.data;
      end
      short_q_ff <= short_mem[rd_addr[SAW-1:0]];
      sel_ff     <= rd_short;
   end

   assign rd_gain = !built_ff ? '0 : (sel_ff ? short_q_ff : long_q_ff);

endmodule
`default_nettype wire

/* rtl/core/mdct_line_equalizer_core.sv */
// Spectral line equalizer.
// req channel (valid/ready) carries two kinds of beat: req_type 0 sets one
// band (dB step and center), req_type 1 scales one spectral sample. Only a
// sample beat produces a rsp beat, in request order.
// A band write reads and compares the band entry, then writes it if changed.
// A sample passes through the gain memory read, the 20x32 multiply and the
// output register before rsp_valid; the next beat is taken once the block
// returns to idle, so one item is in flight at a time.
// When a band value changed since the last sample, the first sample after it
// first rebuilds both gain memories: 576 + 192 line writes plus, per band
// crossing, a reload of the next band and a slope divide.
// csr_wr_en/csr_wr_data set the sample rate; it takes effect at the next
// rebuild. Write it only while idle.
// Reset clears band memory validity, sets the sample rate to 44100, marks the
// gain memories unbuilt: samples come out as zero until a band value changes.
// A stalled rsp holds its beat; a following sample stops in the output stage
// until the beat is taken.
`default_nettype none
module mdct_line_equalizer_core #(
   parameter int NUM_BANDS      = mle_pkg::NUM_BANDS_DEF,
   parameter int LONG_LINES     = mle_pkg::LONG_LINES_DEF,
   parameter int SHORT_LINES    = mle_pkg::SHORT_LINES_DEF,
   parameter int GAIN_FRAC_BITS = mle_pkg::GAIN_FRAC_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_type,
   input  wire logic [3:0]                          req_band_index,
   input  wire logic signed [mle_pkg::DB_W-1:0]     req_band_db,
   input  wire logic [mle_pkg::CENTER_W-1:0]        req_band_center,
   input  wire logic signed [mle_pkg::SAMPLE_W-1:0] req_sample_in,
   input  wire logic [mle_pkg::LINE_W-1:0]          req_line_index,
   input  wire logic                                req_short_block,
   input  wire logic                                req_mixed_block,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [mle_pkg::SAMPLE_W-1:0]      rsp_sample_out,
   input  wire logic                                csr_wr_en,
   input  wire logic [mle_pkg::RATE_W-1:0]          csr_wr_data
);
   import mle_pkg::*;

   localparam int BAW    = $clog2(NUM_BANDS);
   localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
   localparam int HI_W   = RATE_W - RATE_PRE_SH;
   localparam int L3_W   = 2 * LINE_W + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_BCMP, S_BUILD, S_GRD, S_GMUL, S_GOUT
   } state_type;

   state_type                  state_ff;
   logic [RATE_W-1:0]          rate_ff;
   logic                       stale_ff;
   logic [BAW-1:0]             bidx_ff;
   logic                       wr_ok_ff;
   band_ent_type               bent_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [LINE_W-1:0]          line_ff;
   logic                       short_ff;
   logic                       mixed_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   logic                       req_accept;
   logic [HI_W-1:0]            rate_hi;
   logic [HI_W+STEP_W-1:0]     step_l_full;
   logic [HI_W+STEP_W-1:0]     step_s_full;
   logic [STEP_W-1:0]          step_long;
   logic [STEP_W-1:0]          step_short;
   logic [BAW-1:0]             bld_raddr;
   logic [BAW-1:0]             band_raddr;
   band_ent_type               band_rdata;
   band_ent_type               band_wdata;
   logic                       band_we;
   gain_wr_type                gain_wr;
   bld_stat_type               bld_stat;
   logic                       bld_start;
   logic                       use_long;
   logic [LINE_W-1:0]          long_k;
   logic [L3_W-1:0]            l3_full;
   logic [LINE_W-1:0]          short_k;
   logic [LINE_W-1:0]          gain_raddr;
   logic [GAIN_W-1:0]          rd_gain;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_sh;
   logic                       out_free;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign bld_start  = req_accept && req_type && stale_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign rate_hi     = rate_ff[RATE_W-1:RATE_PRE_SH];
   assign step_l_full = (HI_W+STEP_W)'(rate_hi) * (HI_W+STEP_W)'(RECIP9);
   assign step_s_full = (HI_W+STEP_W)'(rate_hi) * (HI_W+STEP_W)'(RECIP3_STEP);
   assign step_long   = STEP_W'(step_l_full >> RECIP_STEP_SH);
   assign step_short  = STEP_W'(step_s_full >> RECIP_STEP_SH);

   assign band_raddr = (state_ff == S_IDLE) ? BAW'(req_band_index) : bld_raddr;
   assign band_we    = (state_ff == S_BCMP) && wr_ok_ff
                    && ((band_rdata.db != bent_ff.db)
                        || (band_rdata.center != bent_ff.center));
   assign band_wdata = bent_ff;

   assign use_long   = !short_ff || (mixed_ff && (line_ff < LINE_W'(MIXED_LONG_LINES)));
   assign long_k     = (line_ff > LINE_W'(LONG_LINES - 1)) ? LINE_W'(LONG_LINES - 1) : line_ff;
   assign l3_full    = L3_W'(line_ff) * L3_W'(RECIP3_LINE);
   assign short_k    = (LINE_W'(l3_full >> RECIP_LINE_SH) > LINE_W'(SHORT_LINES - 1))
                     ? LINE_W'(SHORT_LINES - 1) : LINE_W'(l3_full >> RECIP_LINE_SH);
   assign gain_raddr = use_long ? long_k : short_k;

   assign prod_in = $signed({1'b0, rd_gain}) * sample_ff;
   assign prod_sh = prod_ff >>> GAIN_FRAC_BITS;

   mle_band_store #(
      .NUM_BANDS(NUM_BANDS)
   ) u_band (
      .clock(clock),
      .reset(reset),
      .wr_en(band_we),
      .wr_addr(bidx_ff),
      .wr_data(band_wdata),
      .rd_addr(band_raddr),
      .rd_data(band_rdata)
   );

   mle_gain_builder #(
      .NUM_BANDS(NUM_BANDS),
      .LONG_LINES(LONG_LINES),
      .SHORT_LINES(SHORT_LINES)
   ) u_build (
      .clock(clock),
      .reset(reset),
      .start(bld_start),
      .step_long(step_long),
      .step_short(step_short),
      .band_raddr(bld_raddr),
      .band_rdata(band_rdata),
      .gain_wr(gain_wr),
      .stat(bld_stat)
   );

   mle_gain_store #(
      .LONG_LINES(LONG_LINES),
      .SHORT_LINES(SHORT_LINES)
   ) u_gain (
      .clock(clock),
      .reset(reset),
      .gain_wr(gain_wr),
      .fill_done(bld_stat.done),
      .rd_short(!use_long),
      .rd_addr(gain_raddr),
      .rd_gain(rd_gain)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_wr_en) begin
         rate_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stale_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !((state_ff == S_GOUT) && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  bidx_ff        <= BAW'(req_band_index);
                  wr_ok_ff       <= int'(req_band_index) < NUM_BANDS;
                  bent_ff.db     <= req_band_db;
                  bent_ff.center <= req_band_center;
                  sample_ff      <= req_sample_in;
                  line_ff        <= req_line_index;
                  short_ff       <= req_short_block;
                  mixed_ff       <= req_mixed_block;
                  priority if (!req_type)
                     state_ff <= S_BCMP;
                  else if (stale_ff)
                     state_ff <= S_BUILD;
                  else
                     state_ff <= S_GRD;
               end
            end
            S_BCMP: begin
               if (band_we) begin
                  stale_ff <= 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_BUILD: begin
               if (bld_stat.done) begin
                  stale_ff <= 1'b0;
                  state_ff <= S_GRD;
               end
            end
            S_GRD: state_ff <= S_GMUL;
            S_GMUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_GOUT;
            end
            S_GOUT: begin
               if (out_free) begin
                  rsp_data_ff  <= prod_sh[SAMPLE_W-1:0];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

`ifndef SYNTHESIS
   a_done_clears_stale: assert property (@(posedge clock) disable iff (reset)
      bld_stat.done |=> !stale_ff)
      else $error("gain rebuild finished but tables still marked stale");

   a_gain_wr_in_build: assert property (@(posedge clock) disable iff (reset)
      gain_wr.we |-> state_ff == S_BUILD)
      else $error("gain memory written outside a rebuild");

   a_build_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_BUILD |-> bld_stat.busy || bld_stat.done)
      else $error("waiting on a rebuild that is not running");
`endif

endmodule
`default_nettype wire
